// ----- sv/affine_gap_alignment_scorer_assert.svh -----
// assertion helpers, clocked on clk and disabled during rst
`ifndef AFFINE_GAP_ALIGNMENT_SCORER_ASSERT_SVH
`define AFFINE_GAP_ALIGNMENT_SCORER_ASSERT_SVH

// same-cycle implication
`define AGAS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("agas assertion failed");

// next-cycle implication
`define AGAS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("agas assertion failed");

`endif

// ----- sv/agas_pkg.sv -----
package agas_pkg;

  localparam int MAX_LEN    = 256;
  localparam int LEN_W      = $clog2(MAX_LEN + 1);
  localparam int SYM_AW     = $clog2(MAX_LEN);
  localparam int ROW_DEPTH  = MAX_LEN + 1;
  localparam int CELL_W     = 20;
  localparam int WIDE_W     = 22;
  localparam int CELL_BITS  = 3 * CELL_W;

  localparam logic signed [CELL_W-1:0] NEG_INF  = -20'sd100000;
  localparam logic signed [CELL_W-1:0] CELL_MAX = 20'sh7FFFF;
  localparam logic signed [CELL_W-1:0] CELL_MIN = 20'sh80000;

  localparam logic [1:0] MODE_FIRST  = 2'd0;
  localparam logic [1:0] MODE_SECOND = 2'd1;
  localparam logic [1:0] MODE_RUN    = 2'd2;

  localparam logic [2:0] REG_KIND       = 3'd0;
  localparam logic [2:0] REG_MATCH      = 3'd1;
  localparam logic [2:0] REG_MISMATCH   = 3'd2;
  localparam logic [2:0] REG_GAP_OPEN   = 3'd3;
  localparam logic [2:0] REG_GAP_EXTEND = 3'd4;

  typedef enum logic [1:0] {
    KIND_GLOBAL,
    KIND_LOCAL,
    KIND_ENDS_FREE,
    KIND_PARTIAL_FREE
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROW_RD,
    ST_ROW_LD,
    ST_CELL_RD,
    ST_CELL_WR,
    ST_ROW_END,
    ST_SCAN_RD,
    ST_SCAN_CK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic signed [CELL_W-1:0] m;
    logic signed [CELL_W-1:0] v;
    logic signed [CELL_W-1:0] h;
  } cell_t;

  typedef struct packed {
    logic signed [7:0] match_sc;
    logic signed [7:0] mismatch_sc;
    logic signed [7:0] gap_open;
    logic signed [7:0] gap_ext;
    logic              local_en;
  } score_cfg_t;

  function automatic logic signed [WIDE_W-1:0] widen_cell(input logic signed [CELL_W-1:0] c);
    widen_cell = signed'({{(WIDE_W-CELL_W){c[CELL_W-1]}}, c});
  endfunction

  function automatic logic signed [WIDE_W-1:0] widen_byte(input logic signed [7:0] b);
    widen_byte = signed'({{(WIDE_W-8){b[7]}}, b});
  endfunction

  function automatic logic signed [WIDE_W-1:0] max3_wide(
    input logic signed [WIDE_W-1:0] a,
    input logic signed [WIDE_W-1:0] b,
    input logic signed [WIDE_W-1:0] c
  );
    logic signed [WIDE_W-1:0] t;
    t = (a > b) ? a : b;
    max3_wide = (t > c) ? t : c;
  endfunction

  function automatic logic signed [CELL_W-1:0] cell_best(input cell_t c);
    logic signed [CELL_W-1:0] t;
    t = (c.m > c.v) ? c.m : c.v;
    cell_best = (t > c.h) ? t : c.h;
  endfunction

  function automatic logic signed [CELL_W-1:0] clamp_cell(input logic signed [WIDE_W-1:0] w);
    if (w > widen_cell(CELL_MAX)) begin
      clamp_cell = CELL_MAX;
    end else if (w < widen_cell(CELL_MIN)) begin
      clamp_cell = CELL_MIN;
    end else begin
      clamp_cell = w[CELL_W-1:0];
    end
  endfunction

endpackage

// ----- sv/agas_ram.sv -----
module agas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/agas_cell.sv -----
module agas_cell (
  input  agas_pkg::score_cfg_t             cfg,
  input  logic                             sym_eq,
  input  agas_pkg::cell_t                  diag,
  input  agas_pkg::cell_t                  up,
  input  agas_pkg::cell_t                  left,
  output agas_pkg::cell_t                  cell_new,
  output logic signed [agas_pkg::CELL_W-1:0] cell_max
);
  import agas_pkg::*;

  logic signed [WIDE_W-1:0] s_w, go_w, ge_w;
  logic signed [WIDE_W-1:0] m_w, v_w, h_w;

  always_comb begin
    s_w  = widen_byte(sym_eq ? cfg.match_sc : cfg.mismatch_sc);
    go_w = widen_byte(cfg.gap_open);
    ge_w = widen_byte(cfg.gap_ext);
    m_w  = s_w + max3_wide(widen_cell(diag.m), widen_cell(diag.v), widen_cell(diag.h));
    v_w  = max3_wide(go_w + widen_cell(up.m), ge_w + widen_cell(up.v),
                     go_w + widen_cell(up.h));
    h_w  = max3_wide(go_w + widen_cell(left.m), ge_w + widen_cell(left.h),
                     go_w + widen_cell(left.v));
    if (cfg.local_en) begin
      if (m_w < 0) m_w = '0;
      if (v_w < 0) v_w = '0;
      if (h_w < 0) h_w = '0;
    end
    cell_new.m = clamp_cell(m_w);
    cell_new.v = clamp_cell(v_w);
    cell_new.h = clamp_cell(h_w);
    cell_max   = cell_best(cell_new);
  end

endmodule

// ----- sv/affine_gap_alignment_scorer.sv -----
// affine-gap alignment scorer
// input item: start with mode/symbol, accepted when start is high and busy low.
// mode 0 / 1 appends symbol to the first / second sequence, no
// result; a symbol past 256 is dropped and flagged. mode 2 runs the alignment
// with the kind and scores in the config registers (cfg_we/cfg_index/cfg_data,
// written by the user only while idle; the block does not enforce this) and
// gives one result: done high for exactly one cycle with score, end_first,
// end_second and overflow. the receiver cannot stall. mode 3 is ignored.
// each cell uses the row memory's registered read, then the shared cell unit
// writes the new cell back. busy is high for the whole run; appends can come
// back to back.
// after a run both lengths and the internal drop flag return to zero.
// reset (rst, synchronous) empties both sequences and loads default scores;
// the symbol and row memories are not cleared.
module affine_gap_alignment_scorer (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          mode,
  input  logic [7:0]          symbol,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  output logic                done,
  output logic signed [19:0]  score,
  output logic signed [8:0]   end_first,
  output logic signed [8:0]   end_second,
  output logic                overflow
);
  import agas_pkg::*;

  state_t state, state_next;

  kind_t             kind;
  logic signed [7:0] match_sc, mismatch_sc, gap_open, gap_ext;

  logic [LEN_W-1:0] first_len, second_len;
  logic             dropped;
  logic [LEN_W-1:0] i, j, im1, jm1;
  logic signed [CELL_W-1:0] hacc, vacc, best;
  logic [LEN_W-1:0] e1, e2;
  cell_t            diag, left, row0_cell, col_cell, cell_new, row_rdata_c;
  logic [7:0]       s1;
  logic signed [CELL_W-1:0] cell_max;
  score_cfg_t       cfg;
  logic             free_row, free_col, accept;

  logic                 seq1_we, seq2_we, seq1_re, seq2_re;
  logic [7:0]           seq1_rdata, seq2_rdata;
  logic                 row_we, row_re;
  logic [LEN_W-1:0]     row_waddr, row_raddr;
  logic [CELL_BITS-1:0] row_wdata, row_rdata;

  assign accept   = start && !busy;
  assign busy     = (state != ST_IDLE);
  assign free_row = (kind != KIND_GLOBAL);
  assign free_col = (kind == KIND_LOCAL) || (kind == KIND_ENDS_FREE);
  assign im1      = i - 1'b1;
  assign jm1      = j - 1'b1;
  assign row_rdata_c = cell_t'(row_rdata);

  assign cfg.match_sc    = match_sc;
  assign cfg.mismatch_sc = mismatch_sc;
  assign cfg.gap_open    = gap_open;
  assign cfg.gap_ext     = gap_ext;
  assign cfg.local_en    = (kind == KIND_LOCAL);

  always_comb begin
    if (j == '0) begin
      row0_cell.m = '0;
      row0_cell.v = NEG_INF;
      row0_cell.h = NEG_INF;
    end else begin
      row0_cell.m = NEG_INF;
      row0_cell.v = NEG_INF;
      row0_cell.h = free_row ? '0 : hacc;
    end
    col_cell.m = NEG_INF;
    col_cell.v = free_col ? '0 : vacc;
    col_cell.h = NEG_INF;
  end

  agas_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_seq1 (
    .clk(clk), .we(seq1_we), .waddr(first_len[SYM_AW-1:0]), .wdata(symbol),
    .re(seq1_re), .raddr(im1[SYM_AW-1:0]), .rdata(seq1_rdata)
  );

  agas_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_seq2 (
    .clk(clk), .we(seq2_we), .waddr(second_len[SYM_AW-1:0]), .wdata(symbol),
    .re(seq2_re), .raddr(jm1[SYM_AW-1:0]), .rdata(seq2_rdata)
  );

  agas_ram #(.WIDTH(CELL_BITS), .DEPTH(ROW_DEPTH)) u_rows (
    .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
    .re(row_re), .raddr(row_raddr), .rdata(row_rdata)
  );

  agas_cell u_cell (
    .cfg(cfg), .sym_eq(s1 == seq2_rdata), .diag(diag), .up(row_rdata_c),
    .left(left), .cell_new(cell_new), .cell_max(cell_max)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    seq1_we    = 1'b0;
    seq2_we    = 1'b0;
    seq1_re    = 1'b0;
    seq2_re    = 1'b0;
    row_we     = 1'b0;
    row_re     = 1'b0;
    row_waddr  = j;
    row_raddr  = j;
    row_wdata  = cell_new;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (mode)
            MODE_FIRST:  seq1_we = (first_len < LEN_W'(MAX_LEN));
            MODE_SECOND: seq2_we = (second_len < LEN_W'(MAX_LEN));
            MODE_RUN:    state_next = ST_INIT;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_INIT: begin
        row_we    = 1'b1;
        row_wdata = row0_cell;
        if (j == second_len) begin
          if (first_len != '0) begin
            state_next = ST_ROW_RD;
          end else if (kind inside {KIND_ENDS_FREE, KIND_PARTIAL_FREE} &&
                       second_len != '0) begin
            state_next = ST_SCAN_RD;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_ROW_RD: begin
        row_re     = 1'b1;
        row_raddr  = '0;
        seq1_re    = 1'b1;
        state_next = ST_ROW_LD;
      end
      ST_ROW_LD: begin
        row_we     = 1'b1;
        row_waddr  = '0;
        row_wdata  = col_cell;
        state_next = (second_len == '0) ? ST_ROW_END : ST_CELL_RD;
      end
      ST_CELL_RD: begin
        row_re     = 1'b1;
        seq2_re    = 1'b1;
        state_next = ST_CELL_WR;
      end
      ST_CELL_WR: begin
        row_we     = 1'b1;
        state_next = (j == second_len) ? ST_ROW_END : ST_CELL_RD;
      end
      ST_ROW_END: begin
        if (i != first_len) begin
          state_next = ST_ROW_RD;
        end else if (kind inside {KIND_ENDS_FREE, KIND_PARTIAL_FREE} &&
                     second_len != '0) begin
          state_next = ST_SCAN_RD;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_SCAN_RD: begin
        row_re     = 1'b1;
        state_next = ST_SCAN_CK;
      end
      ST_SCAN_CK: begin
        state_next = (j == second_len) ? ST_FINISH : ST_SCAN_RD;
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kind        <= KIND_GLOBAL;
      match_sc    <= 8'sd1;
      mismatch_sc <= -8'sd1;
      gap_open    <= -8'sd2;
      gap_ext     <= -8'sd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KIND:       kind        <= kind_t'(cfg_data[1:0]);
        REG_MATCH:      match_sc    <= cfg_data;
        REG_MISMATCH:   mismatch_sc <= cfg_data;
        REG_GAP_OPEN:   gap_open    <= cfg_data;
        REG_GAP_EXTEND: gap_ext     <= cfg_data;
        default: ;
      endcase
    end
  end

  // lengths, overflow flag and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      first_len  <= '0;
      second_len <= '0;
      dropped    <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= (state == ST_FINISH);
      if (state == ST_FINISH) begin
        first_len  <= '0;
        second_len <= '0;
        dropped    <= 1'b0;
      end else if (state == ST_IDLE && accept) begin
        if (mode == MODE_FIRST) begin
          if (first_len < LEN_W'(MAX_LEN)) first_len <= first_len + 1'b1;
          else dropped <= 1'b1;
        end else if (mode == MODE_SECOND) begin
          if (second_len < LEN_W'(MAX_LEN)) second_len <= second_len + 1'b1;
          else dropped <= 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        best <= (kind == KIND_LOCAL) ? '0 : NEG_INF;
        e1   <= '0;
        e2   <= '0;
        i    <= LEN_W'(1);
        j    <= '0;
        hacc <= CELL_W'(gap_open);
        vacc <= CELL_W'(gap_open);
      end
      ST_INIT: begin
        left <= row0_cell;
        if (j != '0) hacc <= hacc + CELL_W'(gap_ext);
        j <= (j == second_len) ? '0 : j + 1'b1;
      end
      ST_ROW_LD: begin
        diag <= row_rdata_c;
        s1   <= seq1_rdata;
        left <= col_cell;
        j    <= LEN_W'(1);
      end
      ST_CELL_WR: begin
        diag <= row_rdata_c;
        left <= cell_new;
        if (kind == KIND_LOCAL && cell_max > best) begin
          best <= cell_max;
          e1   <= i;
          e2   <= j;
        end
        if (j != second_len) j <= j + 1'b1;
      end
      ST_ROW_END: begin
        // ends-free checks the last column once per row
        if (kind == KIND_ENDS_FREE && cell_best(left) > best) begin
          best <= cell_best(left);
          e1   <= i;
          e2   <= second_len;
        end
        vacc <= vacc + CELL_W'(gap_ext);
        i    <= i + 1'b1;
        j    <= LEN_W'(1);
      end
      ST_SCAN_RD: begin
        if (j == '0) j <= LEN_W'(1);
      end
      ST_SCAN_CK: begin
        if (cell_best(row_rdata_c) > best) begin
          best <= cell_best(row_rdata_c);
          e1   <= first_len;
          e2   <= j;
        end
        j <= j + 1'b1;
      end
      ST_FINISH: begin
        overflow <= dropped;
        if (kind == KIND_GLOBAL) begin
          score      <= cell_best(left);
          end_first  <= signed'(first_len - 1'b1);
          end_second <= signed'(second_len - 1'b1);
        end else begin
          score      <= best;
          end_first  <= signed'(e1 - 1'b1);
          end_second <= signed'(e2 - 1'b1);
        end
      end
      default: ;
    endcase
  end

`include "affine_gap_alignment_scorer_assert.svh"

  `AGAS_ASSERT_NXT(a_run_goes_busy, start && !busy && mode == MODE_RUN, busy)
  `AGAS_ASSERT_NXT(a_finish_strobes, state == ST_FINISH, done && !busy)
  `AGAS_ASSERT_IMP(a_col_in_range, state == ST_CELL_WR, j != '0 && j <= second_len)

endmodule
